// File: rtl/indexed_insert_remove_list_core_defines.svh
// Assertion macros used by the list core control block.
`ifndef INDEXED_INSERT_REMOVE_LIST_CORE_DEFINES_SVH
`define INDEXED_INSERT_REMOVE_LIST_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, muted during reset.
`define IIRL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, muted during reset.
`define IIRL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/iirl_pkg.sv
// Shared types and codes for the indexed insert/remove list core.
`default_nettype none

package iirl_pkg;

	// Operation code carried in the input beat
	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	// Result status code
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Move broadcast to every cell in the chain
	typedef enum logic [1:0] {
		SH_HOLD = 2'd0,
		SH_INS  = 2'd1,
		SH_REM  = 2'd2
	} shift_t;

endpackage

`default_nettype wire

// File: rtl/iirl_cell.sv
// One list slot: holds a word and moves it to or from its neighbors.
`default_nettype none

module iirl_cell #(
	parameter int DATA_W = 32,
	parameter int CW     = 5,
	parameter int IDX    = 0
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire iirl_pkg::shift_t  kind,
	input  wire logic [CW-1:0]     pos,
	input  wire logic [CW-1:0]     count,
	input  wire logic [DATA_W-1:0] value,
	input  wire logic [DATA_W-1:0] left,
	input  wire logic [DATA_W-1:0] right,
	output logic      [DATA_W-1:0] data
);

	localparam logic [CW-1:0] MY_IDX  = CW'(IDX);
	localparam logic [CW-1:0] MY_IDX1 = CW'(IDX + 1);

	logic [DATA_W-1:0] data_q;
	logic [DATA_W-1:0] data_nxt;

	// Pick the next word for this slot
	always_comb begin
		data_nxt = data_q;
		unique case (kind)
			iirl_pkg::SH_INS: begin
				if (MY_IDX == pos) begin
					data_nxt = value;
				end else if (MY_IDX > pos && MY_IDX <= count) begin
					data_nxt = left;
				end
			end
			iirl_pkg::SH_REM: begin
				if (MY_IDX1 == count) begin
					data_nxt = '0;
				end else if (MY_IDX >= pos && MY_IDX1 < count) begin
					data_nxt = right;
				end
			end
			default: begin
				data_nxt = data_q;
			end
		endcase
	end

	// Hold the slot word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
		end else begin
			data_q <= data_nxt;
		end
	end

	assign data = data_q;

endmodule

`default_nettype wire

// File: rtl/iirl_ctrl.sv
// Count keeper, status decode and result register of the list core.
`default_nettype none

`include "indexed_insert_remove_list_core_defines.svh"

module iirl_ctrl #(
	parameter int CAPACITY = 16,
	parameter int DATA_W   = 32,
	parameter int CW       = 5
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              op,
	input  wire logic [CW-1:0]     pos,
	input  wire logic [DATA_W-1:0] sel_data,
	output iirl_pkg::shift_t       kind,
	output logic      [CW-1:0]     count,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output iirl_pkg::status_t      status,
	output logic      [DATA_W-1:0] removed
);

	localparam logic [CW-1:0] CAP = CW'(CAPACITY);

	logic              vld_q;
	logic [CW-1:0]     count_q;
	iirl_pkg::status_t status_q;
	logic [DATA_W-1:0] removed_q;

	logic              fire;
	iirl_pkg::status_t st_nxt;
	iirl_pkg::shift_t  kind_dec;
	logic [CW-1:0]     count_nxt;

	// Take a beat when the result slot is empty or drains this cycle
	assign in_ready = !vld_q || out_ready;
	assign fire     = in_valid && in_ready;

	// Decode the operation against the current count
	always_comb begin
		st_nxt    = iirl_pkg::ST_OK;
		kind_dec  = iirl_pkg::SH_HOLD;
		count_nxt = count_q;
		unique case (iirl_pkg::op_t'(op))
			iirl_pkg::OP_INSERT: begin
				if (pos > count_q) begin
					st_nxt = iirl_pkg::ST_RANGE;
				end else if (count_q >= CAP) begin
					st_nxt = iirl_pkg::ST_FULL;
				end else begin
					kind_dec  = iirl_pkg::SH_INS;
					count_nxt = count_q + 1'b1;
				end
			end
			iirl_pkg::OP_REMOVE: begin
				if (pos >= count_q) begin
					st_nxt = iirl_pkg::ST_RANGE;
				end else begin
					kind_dec  = iirl_pkg::SH_REM;
					count_nxt = count_q - 1'b1;
				end
			end
			default: begin
				st_nxt = iirl_pkg::ST_OK;
			end
		endcase
	end

	assign kind = fire ? kind_dec : iirl_pkg::SH_HOLD;

	// Control state: result valid and entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= 1'b0;
			count_q <= '0;
		end else begin
			if (fire) begin
				vld_q   <= 1'b1;
				count_q <= count_nxt;
			end else if (out_ready) begin
				vld_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (fire) begin
			status_q  <= st_nxt;
			removed_q <= (kind_dec == iirl_pkg::SH_REM) ? sel_data : '0;
		end
	end

	assign count     = count_q;
	assign out_valid = vld_q;
	assign status    = status_q;
	assign removed   = removed_q;

	`IIRL_ASSERT_NOW(a_count_max, 1'b1, count_q <= CAP, "entry count above capacity")
	`IIRL_ASSERT_NEXT(a_ins_grow, fire && kind_dec == iirl_pkg::SH_INS,
		count_q == $past(count_q) + 1'b1, "insert did not grow count")
	`IIRL_ASSERT_NEXT(a_fail_hold, fire && st_nxt != iirl_pkg::ST_OK,
		$stable(count_q), "failed operation changed count")
	`IIRL_ASSERT_NOW(a_removed_ok, vld_q && removed_q != '0,
		status_q == iirl_pkg::ST_OK, "removed word on failed operation")

endmodule

`default_nettype wire

// File: rtl/indexed_insert_remove_list_core.sv
// Indexed insert/remove list: top level with the chain of slot cells.
//
// Input stream (s_*): one beat per operation, insert or remove at a list
// position; the word field is ignored on remove. Output stream (m_*): one
// beat per operation with status, the removed word and the new entry count.
// Insert is legal at positions 0..count, remove at 0..count-1; a position
// out of range or an insert into a full list returns an error status and
// leaves the list untouched.
// The result is registered, offered in the cycle after the input beat is
// taken. Throughput is one operation per cycle unless the receiver
// stalls: every slot cell shifts in parallel in the cycle the beat is
// taken, so the count register is the only loop between beats. A new
// beat is taken while the previous result is handed off in the same
// cycle. When the receiver stalls the result holds and s_tready drops until it is taken.
// Reset clears all slots to zero and the count to zero; no clearing pass.
`default_nettype none

module indexed_insert_remove_list_core #(
	parameter int CAPACITY = 16,
	parameter int DATA_W   = 32,
	localparam int CW      = $clog2(CAPACITY + 1),
	localparam int IN_W    = ((1 + CW + DATA_W + 7) / 8) * 8,
	localparam int OUT_W   = ((2 + DATA_W + CW + 7) / 8) * 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	// operation[0], position[CW:1], value[CW+DATA_W:CW+1], zero fill above
	input  wire logic [IN_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	// status[1:0], removed_value[DATA_W+1:2], entry_count above, zero fill
	output logic      [OUT_W-1:0] m_tdata
);

	localparam int IW = $clog2(CAPACITY);

	logic                  op;
	logic [CW-1:0]         pos;
	logic [DATA_W-1:0]     value;
	iirl_pkg::shift_t      kind;
	logic [CW-1:0]         count;
	iirl_pkg::status_t     status;
	logic [DATA_W-1:0]     removed;
	logic [DATA_W-1:0]     sel_data;
	logic [DATA_W-1:0]     cell_data [CAPACITY];

	// Unpack the input beat
	assign op    = s_tdata[0];
	assign pos   = s_tdata[CW:1];
	assign value = s_tdata[CW+DATA_W:CW+1];

	// Word at the requested position, used only on a legal remove
	assign sel_data = cell_data[pos[IW-1:0]];

	iirl_ctrl #(
		.CAPACITY (CAPACITY),
		.DATA_W   (DATA_W),
		.CW       (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.op        (op),
		.pos       (pos),
		.sel_data  (sel_data),
		.kind      (kind),
		.count     (count),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.status    (status),
		.removed   (removed)
	);

	// Chain of slot cells, each wired to its two neighbors
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [DATA_W-1:0] left_w;
		logic [DATA_W-1:0] right_w;

		if (g == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cell_data[g-1];
		end

		if (g == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = cell_data[g+1];
		end

		iirl_cell #(
			.DATA_W (DATA_W),
			.CW     (CW),
			.IDX    (g)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.kind   (kind),
			.pos    (pos),
			.count  (count),
			.value  (value),
			.left   (left_w),
			.right  (right_w),
			.data   (cell_data[g])
		);
	end

	// Pack the result beat
	assign m_tdata = OUT_W'({count, removed, status});

endmodule

`default_nettype wire
